FILE: src/slru_pkg.sv
// Shared types and constants for the segmented LRU cache.
// Holds the slot scan record, the slot update command and their codes.
// No dependencies.
`default_nettype none
package slru_pkg;

	localparam int ENTRIES = 64;
	localparam int IDX_W = $clog2(ENTRIES);
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam int KEY_W = 32;
	localparam int SIZE_W = 24;
	localparam int LVL_W = 2;
	localparam int REC_W = 16;
	localparam int BYTES_W = 33;
	localparam int SUM_W = BYTES_W + 2;
	localparam int CAP_W = 32;
	localparam int CTR_W = 32;
	localparam int EVC_W = 7;
	localparam int LEVELS = 3;

	localparam logic [LVL_W-1:0] LVL_TOP = 2'd0;
	localparam logic [LVL_W-1:0] LVL_MID = 2'd1;
	localparam logic [LVL_W-1:0] LVL_BOT = 2'd2;
	localparam logic [LVL_W-1:0] LVL_MISS = 2'd3;

	localparam logic [CAP_W-1:0] CAP_RESET = 32'd1048576;

	// Slot update operations broadcast along the row of cells.
	localparam logic [1:0] OP_MRU = 2'd0;
	localparam logic [1:0] OP_INVAL = 2'd1;
	localparam logic [1:0] OP_WRITE = 2'd2;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;

	// Search record that travels one cell per cycle.
	typedef struct packed {
		logic vld;
		logic [KEY_W-1:0] key;
		logic [LVL_W-1:0] lvl;
		logic found;
		idx_t fidx;
		logic [LVL_W-1:0] flevel;
		logic [SIZE_W-1:0] fsize;
		logic free_ok;
		idx_t free_idx;
		cnt_t bcnt;
		logic lru_ok;
		idx_t lru_idx;
		logic [REC_W-1:0] lru_age;
		logic [SIZE_W-1:0] lru_size;
	} scan_t;

	// Update command for one slot.
	typedef struct packed {
		logic en;
		logic [1:0] op;
		idx_t idx;
		logic [KEY_W-1:0] key;
		logic [SIZE_W-1:0] size;
		logic [LVL_W-1:0] level;
		logic [REC_W-1:0] stamp;
	} upd_t;

endpackage
`default_nettype wire

FILE: src/slru_cell.sv
// One cache slot of the row: holds the slot contents, folds the slot into the
// passing search record and applies broadcast updates. Uses slru_pkg.
`default_nettype none
module slru_cell (
	input wire logic clk,
	input wire logic arst_n,
	input wire slru_pkg::idx_t cell_idx,
	input wire logic [slru_pkg::REC_W-1:0] rclk,
	input wire slru_pkg::upd_t upd,
	input wire slru_pkg::scan_t rec_in,
	output slru_pkg::scan_t rec_out
);

	logic valid_q;
	logic [slru_pkg::KEY_W-1:0] key_q;
	logic [slru_pkg::SIZE_W-1:0] size_q;
	logic [slru_pkg::LVL_W-1:0] level_q;
	logic [slru_pkg::REC_W-1:0] stamp_q;
	logic vld_q;
	slru_pkg::scan_t rec_q;
	slru_pkg::scan_t rec_nx;
	logic [slru_pkg::REC_W-1:0] age;
	logic sel;

	assign sel = upd.en && (upd.idx == cell_idx);
	assign age = rclk - stamp_q;

	// Fold this slot into the search record.
	always_comb begin
		rec_nx = rec_in;
		if (valid_q && (key_q == rec_in.key) && !rec_in.found) begin
			rec_nx.found = 1'b1;
			rec_nx.fidx = cell_idx;
			rec_nx.flevel = level_q;
			rec_nx.fsize = size_q;
		end
		if (valid_q && (level_q == slru_pkg::LVL_BOT)) begin
			rec_nx.bcnt = rec_in.bcnt + slru_pkg::cnt_t'(1);
		end
		if (!valid_q && !rec_in.free_ok) begin
			rec_nx.free_ok = 1'b1;
			rec_nx.free_idx = cell_idx;
		end
		if (valid_q && (level_q == rec_in.lvl) && (!rec_in.lru_ok || age > rec_in.lru_age)) begin
			rec_nx.lru_ok = 1'b1;
			rec_nx.lru_idx = cell_idx;
			rec_nx.lru_age = age;
			rec_nx.lru_size = size_q;
		end
	end

	// Valid bit of the slot.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (sel) begin
			case (upd.op)
				slru_pkg::OP_INVAL: valid_q <= 1'b0;
				slru_pkg::OP_WRITE: valid_q <= 1'b1;
				default: valid_q <= valid_q;
			endcase
		end
	end

	// Slot contents.
	always_ff @(posedge clk) begin
		if (sel) begin
			case (upd.op)
				slru_pkg::OP_MRU: begin
					level_q <= upd.level;
					stamp_q <= upd.stamp;
				end
				slru_pkg::OP_WRITE: begin
					key_q <= upd.key;
					size_q <= upd.size;
					level_q <= upd.level;
					stamp_q <= upd.stamp;
				end
				default: begin
				end
			endcase
		end
	end

	// Record hand-off to the next cell: the valid flag is reset, the payload is not.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= rec_in.vld;
		end
	end

	always_ff @(posedge clk) begin
		rec_q <= rec_nx;
	end

	always_comb begin
		rec_out = rec_q;
		rec_out.vld = vld_q;
	end

endmodule
`default_nettype wire

FILE: src/segmented_lru_size_aware_cache.sv
// Segmented LRU cache top level: controller plus the row of slot cells.
// Depends on slru_pkg and slru_cell.
// Flow: a top-level hit or an early bypass is transferred after one search of the row;
// other paths pass through further controller states, and each LRU search (rebalance move,
// byte eviction, full-table eviction) sends a record through the row again.
// Throughput: one request at a time; busy is high from the accepting edge until the done
// strobe, and the next request can be taken while done is high. The receiver
// cannot stall. Reset clears all slots, byte totals, counters and sets capacity to 1048576.
`default_nettype none
module segmented_lru_size_aware_cache (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [slru_pkg::CAP_W-1:0] cfg_data,
	input wire logic start,
	output logic busy,
	input wire logic [slru_pkg::KEY_W-1:0] req_key,
	input wire logic [slru_pkg::SIZE_W-1:0] req_size,
	output logic done,
	output logic hit,
	output logic [1:0] hit_level,
	output logic inserted,
	output logic bypassed,
	output logic [slru_pkg::EVC_W-1:0] evicted_count,
	output logic [slru_pkg::CTR_W-1:0] hits_total,
	output logic [slru_pkg::CTR_W-1:0] requests_total
);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_SCAN = 4'd1;
	localparam logic [3:0] ST_DECIDE = 4'd2;
	localparam logic [3:0] ST_RB_CHK = 4'd3;
	localparam logic [3:0] ST_RB_SCAN = 4'd4;
	localparam logic [3:0] ST_EV_CHK = 4'd5;
	localparam logic [3:0] ST_EV_SCAN = 4'd6;
	localparam logic [3:0] ST_FULL_CHK = 4'd7;
	localparam logic [3:0] ST_FULL_SCAN = 4'd8;
	localparam logic [3:0] ST_INSERT = 4'd9;
	localparam logic [3:0] ST_FINISH = 4'd10;

	logic [3:0] state_q;
	logic [slru_pkg::CAP_W-1:0] cap_q;
	logic [slru_pkg::KEY_W-1:0] key_q;
	logic [slru_pkg::SIZE_W-1:0] size_q;
	logic [slru_pkg::BYTES_W-1:0] bytes_q [slru_pkg::LEVELS];
	logic [slru_pkg::REC_W-1:0] rclk_q;
	logic [slru_pkg::CTR_W-1:0] hitcnt_q;
	logic [slru_pkg::CTR_W-1:0] reqcnt_q;
	logic rb_lvl_q;
	logic free_ok_q;
	slru_pkg::idx_t free_idx_q;
	slru_pkg::cnt_t evc_q;
	logic hit_q;
	logic [slru_pkg::LVL_W-1:0] lvl_q;
	logic ins_q;
	logic byp_q;
	logic done_q;
	logic found_q;
	logic [slru_pkg::LVL_W-1:0] flevel_q;
	logic bot_empty_q;
	slru_pkg::idx_t fidx_q;
	logic [slru_pkg::SIZE_W-1:0] fsize_q;

	slru_pkg::scan_t chain [slru_pkg::ENTRIES+1];
	slru_pkg::scan_t launch;
	slru_pkg::scan_t res;
	slru_pkg::upd_t upd;
	logic launch_en;
	logic [slru_pkg::LVL_W-1:0] launch_lvl;

	logic [slru_pkg::SUM_W-1:0] b0_w, b1_w, b2_w, size_w, cap_w;
	logic [slru_pkg::SUM_W-1:0] rb_bytes, rb_x3, upper_sum, total_sum;

	assign cfg_ready = 1'b1;
	assign busy = (state_q != ST_IDLE);
	assign res = chain[slru_pkg::ENTRIES];

	assign b0_w = slru_pkg::SUM_W'(bytes_q[0]);
	assign b1_w = slru_pkg::SUM_W'(bytes_q[1]);
	assign b2_w = slru_pkg::SUM_W'(bytes_q[2]);
	assign size_w = slru_pkg::SUM_W'(size_q);
	assign cap_w = slru_pkg::SUM_W'(cap_q);
	assign rb_bytes = rb_lvl_q ? b1_w : b0_w;
	assign rb_x3 = rb_bytes + {rb_bytes[slru_pkg::SUM_W-2:0], 1'b0};
	assign upper_sum = b0_w + b1_w + size_w;
	assign total_sum = upper_sum + b2_w;

	// Search launches: the record enters the first cell for one cycle.
	always_comb begin
		launch_en = 1'b0;
		launch_lvl = slru_pkg::LVL_BOT;
		unique case (state_q)
			ST_IDLE: launch_en = start;
			ST_RB_CHK: begin
				launch_en = (rb_x3 > cap_w);
				launch_lvl = rb_lvl_q ? slru_pkg::LVL_MID : slru_pkg::LVL_TOP;
			end
			ST_EV_CHK: launch_en = (total_sum > cap_w);
			ST_FULL_CHK: launch_en = !free_ok_q;
			default: launch_en = 1'b0;
		endcase
		launch = '0;
		launch.vld = launch_en;
		launch.key = (state_q == ST_IDLE) ? req_key : key_q;
		launch.lvl = launch_lvl;
	end

	assign chain[0] = launch;

	// Row of slot cells.
	for (genvar i = 0; i < slru_pkg::ENTRIES; i++) begin : g_cell
		slru_cell u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.cell_idx(slru_pkg::idx_t'(i)),
			.rclk(rclk_q),
			.upd(upd),
			.rec_in(chain[i]),
			.rec_out(chain[i+1])
		);
	end

	// Slot update commands.
	always_comb begin
		upd = '0;
		upd.key = key_q;
		upd.size = size_q;
		upd.stamp = rclk_q;
		unique case (state_q)
			ST_DECIDE: begin
				upd.en = found_q;
				upd.op = slru_pkg::OP_MRU;
				upd.idx = fidx_q;
				upd.level = (flevel_q == slru_pkg::LVL_TOP) ? slru_pkg::LVL_TOP
					: flevel_q - 2'd1;
			end
			ST_RB_SCAN: begin
				upd.en = res.vld && res.lru_ok;
				upd.op = slru_pkg::OP_MRU;
				upd.idx = res.lru_idx;
				upd.level = rb_lvl_q ? slru_pkg::LVL_BOT : slru_pkg::LVL_MID;
			end
			ST_EV_SCAN, ST_FULL_SCAN: begin
				upd.en = res.vld && res.lru_ok;
				upd.op = slru_pkg::OP_INVAL;
				upd.idx = res.lru_idx;
			end
			ST_INSERT: begin
				upd.en = 1'b1;
				upd.op = slru_pkg::OP_WRITE;
				upd.idx = free_idx_q;
				upd.level = slru_pkg::LVL_BOT;
			end
			default: upd.en = 1'b0;
		endcase
	end

	// Capacity register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= slru_pkg::CAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			cap_q <= cfg_data;
		end
	end

	// Controller.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			bytes_q[0] <= '0;
			bytes_q[1] <= '0;
			bytes_q[2] <= '0;
			rclk_q <= '0;
			hitcnt_q <= '0;
			reqcnt_q <= '0;
			rb_lvl_q <= 1'b0;
			free_ok_q <= 1'b0;
			free_idx_q <= '0;
			evc_q <= '0;
			hit_q <= 1'b0;
			lvl_q <= slru_pkg::LVL_MISS;
			ins_q <= 1'b0;
			byp_q <= 1'b0;
			done_q <= 1'b0;
			key_q <= '0;
			size_q <= '0;
			found_q <= 1'b0;
			flevel_q <= '0;
			bot_empty_q <= 1'b0;
			fidx_q <= '0;
			fsize_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						key_q <= req_key;
						size_q <= req_size;
						reqcnt_q <= reqcnt_q + slru_pkg::CTR_W'(1);
						hit_q <= 1'b0;
						lvl_q <= slru_pkg::LVL_MISS;
						ins_q <= 1'b0;
						byp_q <= 1'b0;
						evc_q <= '0;
						rb_lvl_q <= 1'b0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (res.vld) begin
						free_ok_q <= res.free_ok;
						free_idx_q <= res.free_idx;
						found_q <= res.found;
						flevel_q <= res.flevel;
						bot_empty_q <= (res.bcnt == '0);
						fidx_q <= res.fidx;
						fsize_q <= res.fsize;
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (found_q) begin
						hit_q <= 1'b1;
						lvl_q <= flevel_q;
						hitcnt_q <= hitcnt_q + slru_pkg::CTR_W'(1);
						rclk_q <= rclk_q + slru_pkg::REC_W'(1);
						case (flevel_q)
							slru_pkg::LVL_MID: begin
								bytes_q[1] <= bytes_q[1] - slru_pkg::BYTES_W'(fsize_q);
								bytes_q[0] <= bytes_q[0] + slru_pkg::BYTES_W'(fsize_q);
								state_q <= ST_RB_CHK;
							end
							slru_pkg::LVL_BOT: begin
								bytes_q[2] <= bytes_q[2] - slru_pkg::BYTES_W'(fsize_q);
								bytes_q[1] <= bytes_q[1] + slru_pkg::BYTES_W'(fsize_q);
								state_q <= ST_RB_CHK;
							end
							default: state_q <= ST_FINISH;
						endcase
					end else if ((upper_sum > cap_w) ||
						(!free_ok_q && bot_empty_q)) begin
						byp_q <= 1'b1;
						state_q <= ST_FINISH;
					end else begin
						state_q <= ST_EV_CHK;
					end
				end
				ST_RB_CHK: begin
					if (rb_x3 > cap_w) begin
						state_q <= ST_RB_SCAN;
					end else if (!rb_lvl_q) begin
						rb_lvl_q <= 1'b1;
					end else begin
						state_q <= ST_FINISH;
					end
				end
				ST_RB_SCAN: begin
					if (res.vld) begin
						if (res.lru_ok) begin
							rclk_q <= rclk_q + slru_pkg::REC_W'(1);
							if (rb_lvl_q) begin
								bytes_q[1] <= bytes_q[1] - slru_pkg::BYTES_W'(res.lru_size);
								bytes_q[2] <= bytes_q[2] + slru_pkg::BYTES_W'(res.lru_size);
							end else begin
								bytes_q[0] <= bytes_q[0] - slru_pkg::BYTES_W'(res.lru_size);
								bytes_q[1] <= bytes_q[1] + slru_pkg::BYTES_W'(res.lru_size);
							end
							state_q <= ST_RB_CHK;
						end else if (!rb_lvl_q) begin
							rb_lvl_q <= 1'b1;
							state_q <= ST_RB_CHK;
						end else begin
							state_q <= ST_FINISH;
						end
					end
				end
				ST_EV_CHK: begin
					state_q <= (total_sum > cap_w) ? ST_EV_SCAN : ST_FULL_CHK;
				end
				ST_EV_SCAN: begin
					if (res.vld) begin
						if (res.lru_ok) begin
							bytes_q[2] <= bytes_q[2] - slru_pkg::BYTES_W'(res.lru_size);
							evc_q <= evc_q + slru_pkg::cnt_t'(1);
							if (!free_ok_q || (res.lru_idx < free_idx_q)) begin
								free_ok_q <= 1'b1;
								free_idx_q <= res.lru_idx;
							end
							state_q <= ST_EV_CHK;
						end else begin
							state_q <= ST_FULL_CHK;
						end
					end
				end
				ST_FULL_CHK: begin
					state_q <= free_ok_q ? ST_INSERT : ST_FULL_SCAN;
				end
				ST_FULL_SCAN: begin
					if (res.vld) begin
						if (res.lru_ok) begin
							bytes_q[2] <= bytes_q[2] - slru_pkg::BYTES_W'(res.lru_size);
							evc_q <= evc_q + slru_pkg::cnt_t'(1);
							free_ok_q <= 1'b1;
							free_idx_q <= res.lru_idx;
							state_q <= ST_INSERT;
						end else begin
							byp_q <= 1'b1;
							state_q <= ST_FINISH;
						end
					end
				end
				ST_INSERT: begin
					bytes_q[2] <= bytes_q[2] + slru_pkg::BYTES_W'(size_q);
					rclk_q <= rclk_q + slru_pkg::REC_W'(1);
					ins_q <= 1'b1;
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					done_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Result ports; the eviction count saturates at the field's maximum.
	assign done = done_q;
	assign hit = hit_q;
	assign hit_level = lvl_q;
	assign inserted = ins_q;
	assign bypassed = byp_q;
	assign evicted_count = (32'(evc_q) > 32'((1 << slru_pkg::EVC_W) - 1))
		? slru_pkg::EVC_W'((1 << slru_pkg::EVC_W) - 1) : slru_pkg::EVC_W'(evc_q);
	assign hits_total = hitcnt_q;
	assign requests_total = reqcnt_q;

endmodule
`default_nettype wire
